>>> hdl/ica_pkg.sv
// ----------------------------------------------------------------------------
// ica_pkg: shared types and constants for the attitude filter
// Fixed widths, atan table and the queue word between front and back.
// ----------------------------------------------------------------------------
package ica_pkg;

  localparam int unsigned CordicStepsDef = 16;
  localparam int unsigned CordicStepsMax = 24;
  localparam int unsigned QueueDepth     = 2;

  localparam logic [15:0] GainReset = 16'd26214;
  localparam logic signed [47:0] Deg180Q16 = 48'sd11796480;
  localparam logic signed [31:0] SatQ7  = 32'sd23040;
  localparam logic [15:0] FullQ7 = 16'd46080;

  // register addresses
  localparam logic [0:0] RegBlendGain = 1'b0;

  // raw sample held in the queue
  typedef struct packed {
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] acc_x;
    logic signed [15:0] acc_y;
    logic signed [15:0] acc_z;
    logic signed [15:0] mag_x;
    logic signed [15:0] mag_y;
    logic signed [15:0] mag_z;
    logic [15:0]        step_time;
    logic               acc_zero;
    logic               yz_zero;
  } sample_t;

  // result word
  typedef struct packed {
    logic [15:0] pitch_angle;
    logic [15:0] roll_angle;
    logic [15:0] heading;
    logic        heading_valid;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQ_R, ST_SQ_L, ST_ROLL, ST_PITCH, ST_HX1, ST_HX2, ST_HY1,
    ST_HY2, ST_HY3, ST_HEAD, ST_INTEG, ST_BLEND, ST_OUT
  } seq_state_e;

  typedef enum logic [1:0] {
    OP_IDLE, OP_NORM, OP_ROT, OP_DONE
  } cordic_state_e;

  // round(atan(2^-i) deg * 2^16)
  function automatic logic [21:0] atan_q16(input logic [4:0] i);
    logic [21:0] v;
    case (i)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117304;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

>>> hdl/ica_front.sv
// ----------------------------------------------------------------------------
// ica_front: input side and sample queue
// Takes sample words, flags zero accel cases and holds them in a short queue.
// ----------------------------------------------------------------------------
module ica_front import ica_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [143:0] s_tdata,
  output logic         q_valid_o,
  input  logic         q_pop_i,
  output sample_t      q_data_o
);

  sample_t mem_q [QueueDepth];
  logic [0:0] wr_q, rd_q;
  logic [1:0] cnt_q;
  sample_t smp;
  logic push;

  // classify incoming word
  always_comb begin
    smp.rate_x    = s_tdata[15:0];
    smp.rate_y    = s_tdata[31:16];
    smp.acc_x     = s_tdata[47:32];
    smp.acc_y     = s_tdata[63:48];
    smp.acc_z     = s_tdata[79:64];
    smp.mag_x     = s_tdata[95:80];
    smp.mag_y     = s_tdata[111:96];
    smp.mag_z     = s_tdata[127:112];
    smp.step_time = s_tdata[143:128];
    smp.yz_zero   = (s_tdata[79:48] == '0);
    smp.acc_zero  = (s_tdata[79:32] == '0);
  end

  assign s_tready  = (cnt_q != 2'(QueueDepth));
  assign push      = s_tvalid && s_tready;
  assign q_valid_o = (cnt_q != '0);
  assign q_data_o  = mem_q[rd_q];

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= smp;
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (q_pop_i) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + 2'(push) - 2'(q_pop_i);
    end
  end

endmodule

>>> hdl/ica_cordic.sv
// ----------------------------------------------------------------------------
// ica_cordic: iterative atan2
// Quadrant fold, one doubling per cycle up to 2^40, then one rotation a cycle.
// ----------------------------------------------------------------------------
module ica_cordic import ica_pkg::*; #(
  parameter int unsigned CordicSteps = CordicStepsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] y_i,
  input  logic signed [63:0] x_i,
  output logic               done_o,
  output logic signed [47:0] z_o
);

  localparam logic signed [63:0] NormLimit = 64'sd1099511627776;

  cordic_state_e st_q, st_d;
  logic signed [63:0] x_q, y_q, x_d, y_d;
  logic signed [47:0] z_q, z_d;
  logic [4:0] i_q, i_d;
  logic signed [63:0] ay, m, dx, dy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= OP_IDLE;
    else st_q <= st_d;
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; y_q <= y_d; z_q <= z_d; i_q <= i_d;
  end

  assign ay = y_q[63] ? -y_q : y_q;
  assign m  = (ay > x_q) ? ay : x_q;
  assign dx = y_q >>> i_q;
  assign dy = x_q >>> i_q;
  assign done_o = (st_q == OP_DONE);
  assign z_o = z_q;

  // fold, normalize, rotate
  always_comb begin
    st_d = st_q; x_d = x_q; y_d = y_q; z_d = z_q; i_d = i_q;
    unique case (st_q) inside
      OP_IDLE, OP_DONE: begin
        if (start_i) begin
          i_d = '0;
          if (x_i == 0 && y_i == 0) begin
            z_d = '0; x_d = '0; y_d = '0; st_d = OP_DONE;
          end else begin
            st_d = OP_NORM;
            if (x_i < 0) begin
              x_d = -x_i; y_d = -y_i;
              z_d = (y_i >= 0) ? Deg180Q16 : -Deg180Q16;
            end else begin
              x_d = x_i; y_d = y_i; z_d = '0;
            end
          end
        end else if (st_q == OP_DONE) begin
          st_d = OP_IDLE;
        end
      end
      OP_NORM: begin
        if (m < NormLimit) begin
          x_d = x_q <<< 1; y_d = y_q <<< 1;
        end else begin
          st_d = OP_ROT;
        end
      end
      OP_ROT: begin
        if (y_q > 0) begin
          x_d = x_q + dx; y_d = y_q - dy; z_d = z_q + 48'(atan_q16(i_q));
        end else begin
          x_d = x_q - dx; y_d = y_q + dy; z_d = z_q - 48'(atan_q16(i_q));
        end
        i_d = i_q + 1'b1;
        if (i_q == 5'(CordicSteps - 1)) st_d = OP_DONE;
      end
      default: st_d = OP_IDLE;
    endcase
  end

endmodule

>>> hdl/ica_sqrt.sv
// ----------------------------------------------------------------------------
// ica_sqrt: iterative floor square root
// Digit recurrence for an 18 bit root of a 36 bit radicand; a new start restarts it.
// ----------------------------------------------------------------------------
module ica_sqrt import ica_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [35:0] v_i,
  output logic        busy_o,
  output logic [17:0] root_o
);

  logic [35:0] v_q, res_q, bit_q;
  logic busy_q;
  logic [35:0] sum;

  assign sum = res_q + bit_q;
  assign busy_o = busy_q;
  assign root_o = res_q[17:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) busy_q <= 1'b0;
    else if (start_i) busy_q <= 1'b1;
    else if (bit_q == 36'd1) busy_q <= 1'b0;
  end

  // digit recurrence, one result bit a step
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q <= v_i; res_q <= '0; bit_q <= 36'd1 << 34;
    end else if (busy_q) begin
      if (v_q >= sum) begin
        v_q <= v_q - sum; res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

endmodule

>>> hdl/ica_back.sv
// ----------------------------------------------------------------------------
// ica_back: filter sequencer
// Square roots, 2-3 atan2 passes, tilt products and blend, one sample a time.
// ----------------------------------------------------------------------------
module ica_back import ica_pkg::*; #(
  parameter int unsigned CordicSteps = CordicStepsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] gain_i,
  input  logic        q_valid_i,
  output logic        q_pop_o,
  input  sample_t     q_data_i,
  output logic        m_tvalid,
  input  logic        m_tready,
  output result_t     res_o
);

  seq_state_e st_q, st_d;
  sample_t s_q;
  logic [17:0] r_q, l_q;
  logic signed [47:0] roll_acc_q, pitch_acc_q;
  logic signed [63:0] hx_q, hy_q, t_q;
  logic signed [15:0] pitch_q, roll_q;
  logic [15:0] head_q;
  logic valid_q, out_q, started_q;

  logic sq_start, sq_busy;
  logic [35:0] sq_in;
  logic [17:0] sq_root;
  logic co_start, co_done;
  logic signed [63:0] co_y, co_x;
  logic signed [47:0] co_z;

  ica_sqrt u_sqrt (.clk_i, .rst_ni, .start_i(sq_start), .v_i(sq_in),
                   .busy_o(sq_busy), .root_o(sq_root));
  ica_cordic #(.CordicSteps(CordicSteps)) u_cordic (.clk_i, .rst_ni,
    .start_i(co_start), .y_i(co_y), .x_i(co_x), .done_o(co_done), .z_o(co_z));

  logic signed [33:0] ax2, ay2, az2;
  assign ax2 = 34'(s_q.acc_x) * 34'(s_q.acc_x);
  assign ay2 = 34'(s_q.acc_y) * 34'(s_q.acc_y);
  assign az2 = 34'(s_q.acc_z) * 34'(s_q.acc_z);
  assign sq_in = (st_q == ST_SQ_R) ? 36'(ay2 + az2) : 36'(ax2 + ay2 + az2);

  logic signed [18:0] rs, ls;
  logic signed [16:0] abz;
  assign rs = {1'b0, r_q};
  assign ls = {1'b0, l_q};
  assign abz = s_q.acc_z[15] ? -17'(s_q.acc_z) : 17'(s_q.acc_z);

  // blend terms: integration registered first, then the weighted sum
  logic signed [63:0] integ_p, integ_r, integ_p_q, integ_r_q, v_p, v_r;
  logic signed [31:0] rnd_p, rnd_r;
  logic signed [17:0] g, gc;
  assign g  = {2'b00, gain_i};
  assign gc = 18'sd65536 - g;
  assign integ_p = 64'(pitch_q) * 8192 + 64'(s_q.rate_y) * $signed({1'b0, s_q.step_time});
  assign integ_r = 64'(roll_q) * 8192 + 64'(s_q.rate_x) * $signed({1'b0, s_q.step_time});
  assign v_p = g * integ_p_q + gc * (64'(pitch_acc_q) * 16);
  assign v_r = g * integ_r_q + gc * (64'(roll_acc_q) * 16);
  assign rnd_p = 32'((v_p + 64'sd268435456) >>> 29);
  assign rnd_r = 32'((v_r + 64'sd268435456) >>> 29);

  function automatic logic signed [15:0] sat(input logic signed [31:0] v);
    if (v > SatQ7) return 16'(SatQ7);
    if (v < -SatQ7) return 16'(-SatQ7);
    return 16'(v);
  endfunction

  logic signed [47:0] hq;
  logic signed [15:0] hq16;
  assign hq = (co_z + 48'sd256) >>> 9;
  assign hq16 = 16'(hq);

  assign q_pop_o  = (st_q == ST_IDLE) && q_valid_i;
  assign m_tvalid = out_q;
  assign res_o = '{pitch_angle: pitch_q, roll_angle: roll_q, heading: head_q,
                   heading_valid: valid_q};

  // start pulses for the shared units
  always_comb begin
    sq_start = 1'b0; co_start = 1'b0; co_y = '0; co_x = '0;
    unique case (st_q) inside
      ST_SQ_R, ST_SQ_L: sq_start = !started_q;
      ST_ROLL: begin
        co_start = !started_q; co_y = 64'(s_q.acc_y); co_x = 64'(s_q.acc_z);
      end
      ST_PITCH: begin
        co_start = !started_q; co_y = 64'(s_q.acc_x); co_x = 64'(rs);
      end
      ST_HEAD: begin
        co_start = !started_q; co_y = hy_q; co_x = hx_q;
      end
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE:  if (q_valid_i) st_d = ST_SQ_R;
      ST_SQ_R:  if (started_q && !sq_busy) st_d = ST_SQ_L;
      ST_SQ_L:  if (started_q && !sq_busy) st_d = ST_ROLL;
      ST_ROLL:  if (started_q && co_done) st_d = ST_PITCH;
      ST_PITCH: if (started_q && co_done) st_d = s_q.acc_zero ? ST_INTEG : ST_HX1;
      ST_HX1:   st_d = ST_HX2;
      ST_HX2:   st_d = ST_HY1;
      ST_HY1:   st_d = ST_HY2;
      ST_HY2:   st_d = ST_HY3;
      ST_HY3:   st_d = ST_HEAD;
      ST_HEAD:  if (started_q && co_done) st_d = ST_INTEG;
      ST_INTEG: st_d = ST_BLEND;
      ST_BLEND: st_d = ST_OUT;
      ST_OUT:   if (!out_q) st_d = ST_IDLE;
      default:  st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; started_q <= 1'b0; out_q <= 1'b0;
      pitch_q <= '0; roll_q <= '0; head_q <= '0; valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      started_q <= (st_d == st_q) && (st_q != ST_IDLE);
      if (out_q && m_tready) out_q <= 1'b0;
      if (st_q == ST_BLEND && (!out_q || m_tready)) begin
        pitch_q <= sat(rnd_p); roll_q <= sat(rnd_r);
        valid_q <= !s_q.acc_zero; out_q <= 1'b1;
      end
      if (st_q == ST_HEAD && started_q && co_done)
        head_q <= hq16[15] ? 16'(hq16 + $signed(FullQ7)) : hq16;
    end
  end

  // datapath registers and tilt product steps
  always_ff @(posedge clk_i) begin
    if (q_pop_o) s_q <= q_data_i;
    if (st_q == ST_SQ_R && started_q && !sq_busy) r_q <= sq_root;
    if (st_q == ST_SQ_L && started_q && !sq_busy) l_q <= sq_root;
    if (st_q == ST_ROLL && started_q && co_done) roll_acc_q <= co_z;
    if (st_q == ST_PITCH && started_q && co_done) pitch_acc_q <= co_z;
    unique case (st_q)
      ST_HX1: t_q <= 64'(s_q.mag_x) * rs + 64'(s_q.mag_z) * s_q.acc_x;
      ST_HX2: hx_q <= s_q.yz_zero ? (s_q.acc_x > 0 ? 64'(s_q.mag_z) : -64'(s_q.mag_z))
                                  : t_q * rs;
      ST_HY1: t_q <= 64'(32'(s_q.mag_x) * 32'(s_q.acc_y));
      ST_HY2: begin
        hy_q <= -(t_q * s_q.acc_x);
        t_q  <= 64'(32'(s_q.mag_y) * 32'(abz));
      end
      ST_HY3: hy_q <= s_q.yz_zero ? 64'(s_q.mag_y)
                      : hy_q + t_q * ls + 64'(32'(s_q.mag_z) * 32'(s_q.acc_y)) * rs;
      ST_INTEG: begin
        integ_p_q <= integ_p;
        integ_r_q <= integ_r;
      end
      default: ;
    endcase
  end

endmodule

>>> hdl/imu_complementary_attitude.sv
// ----------------------------------------------------------------------------
// imu_complementary_attitude: complementary pitch/roll filter with compass
// Front queue takes samples; back sequencer runs sqrt and CORDIC passes.
// ----------------------------------------------------------------------------
// sequence per sample: two 18-step square roots, roll and pitch CORDIC passes
//   (up to 40 doublings, then CordicSteps rotations each), five tilt product
//   steps and a heading pass unless accel is zero, then the two-step blend
// queue: two samples can wait while the back end takes one sample at a time
// reset: gain 0.40, pitch, roll and heading zero, queue empty
module imu_complementary_attitude import ica_pkg::*; #(
  parameter int unsigned CordicSteps = CordicStepsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // rate_x, rate_y, acc_x, acc_y, acc_z, mag_x, mag_y, mag_z, step_time
  input  logic [143:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pitch_angle, roll_angle, heading
  output logic [47:0]  m_axis_tdata,
  // heading_valid
  output logic         m_axis_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [0:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic [15:0] gain_q;
  logic q_valid, q_pop;
  sample_t q_data;
  result_t res;

  assign pready = 1'b1;
  assign prdata = (paddr == RegBlendGain) ? {16'd0, gain_q} : '0;

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) gain_q <= GainReset;
    else if (psel && penable && pwrite && paddr == RegBlendGain) gain_q <= pwdata[15:0];
  end

  ica_front u_front (.clk_i, .rst_ni, .s_tvalid(s_axis_tvalid),
    .s_tready(s_axis_tready), .s_tdata(s_axis_tdata), .q_valid_o(q_valid),
    .q_pop_i(q_pop), .q_data_o(q_data));

  ica_back #(.CordicSteps(CordicSteps)) u_back (.clk_i, .rst_ni, .gain_i(gain_q),
    .q_valid_i(q_valid), .q_pop_o(q_pop), .q_data_i(q_data),
    .m_tvalid(m_axis_tvalid), .m_tready(m_axis_tready), .res_o(res));

  assign m_axis_tdata = {res.heading, res.roll_angle, res.pitch_angle};
  assign m_axis_tuser = res.heading_valid;

endmodule

>>> hdl/ica_checker.sv
// ----------------------------------------------------------------------------
// ica_checker: port checks for the attitude filter
// Output hold rules and saturation range on the result word.
// ----------------------------------------------------------------------------
module ica_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic        pready
);

  // stalled word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed under stall");

  // pitch within saturation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata[15:0]) <= 16'sd23040 &&
                       $signed(m_axis_tdata[15:0]) >= -16'sd23040))
    else $error("pitch out of range");

  // heading wrapped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[47:32] < 16'd46080)
    else $error("heading out of range");

  assert property (@(posedge clk_i) pready)
    else $error("pready low");

endmodule

bind imu_complementary_attitude ica_checker u_chk (.clk_i, .rst_ni, .m_axis_tvalid,
  .m_axis_tready, .m_axis_tdata, .pready);

>>> dv/imu_complementary_attitude_tb.sv
// ----------------------------------------------------------------------------
// imu_complementary_attitude_tb: self-checking bench for the attitude filter
// Drives IMU sample words with random gaps, predicts pitch, roll and heading,
// and compares every result word in order against the prediction.
// ----------------------------------------------------------------------------
module imu_complementary_attitude_tb import ica_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumRandom = 1300;
  localparam int unsigned DrainCycles = 400;

  typedef struct packed {
    logic [15:0] step_time;
    logic signed [15:0] mag_z;
    logic signed [15:0] mag_y;
    logic signed [15:0] mag_x;
    logic signed [15:0] acc_z;
    logic signed [15:0] acc_y;
    logic signed [15:0] acc_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_x;
  } imu_word_t;

  typedef struct packed {
    logic [15:0] pitch;
    logic [15:0] roll;
    logic [15:0] heading;
    logic        valid;
  } attitude_t;

  // directed row: sample plus an optional typed-in expectation
  typedef struct {
    imu_word_t   smp;
    bit          has_exp;
    attitude_t   exp_att;
  } stim_row_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [143:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [47:0]  m_axis_tdata;
  logic         m_axis_tuser;
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [0:0]   paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;

  imu_complementary_attitude i_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // predictor state
  logic [15:0]        mdl_gain;
  logic signed [15:0] mdl_pitch;
  logic signed [15:0] mdl_roll;
  logic [15:0]        mdl_heading;

  attitude_t expected_att_q[$];
  int unsigned n_fail;
  int unsigned n_results;
  int unsigned n_invalid;
  bit          quiet_stretch;

  longint atan_lut [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0
  };

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic longint floor_shr(longint x, int s);
    return x >>> s;
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 34;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  // vectoring atan2 in deg * 2^16
  function automatic longint vec_atan2(longint y, longint x);
    longint z, m, dx, dy, ay;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = (y <= 0) ? 64'sd11796480 : -64'sd11796480;
    end
    ay = (y < 0) ? -y : y;
    m = (ay > x) ? ay : x;
    while (m < 64'sd1099511627776) begin
      x *= 2;
      y *= 2;
      m *= 2;
    end
    for (int i = 0; i < CordicStepsDef; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (y > 0) begin
        x += dx; y -= dy; z += atan_lut[i];
      end else begin
        x -= dx; y += dy; z -= atan_lut[i];
      end
    end
    return z;
  endfunction

  function automatic logic signed [15:0] blend_angle(longint prev, longint rate, longint dt,
                                                     longint acc_ang);
    longint g, a, v, r;
    g = longint'(mdl_gain);
    a = prev * 8192 + rate * dt;
    v = g * a + (65536 - g) * (acc_ang * 16);
    r = floor_shr(v + (64'sd1 << 28), 29);
    if (r > 23040) r = 23040;
    if (r < -23040) r = -23040;
    return r[15:0];
  endfunction

  function automatic attitude_t predict_attitude(imu_word_t s);
    longint ax, ay, az, mx, my, mz, r, l, hx, hy, h, azabs;
    longint roll_ang, pitch_ang;
    attitude_t res;
    ax = s.acc_x; ay = s.acc_y; az = s.acc_z;
    mx = s.mag_x; my = s.mag_y; mz = s.mag_z;
    r = int_sqrt(ay * ay + az * az);
    l = int_sqrt(ax * ax + ay * ay + az * az);
    roll_ang = vec_atan2(ay, az);
    pitch_ang = vec_atan2(ax, r);
    res.valid = !(ax == 0 && ay == 0 && az == 0);
    mdl_pitch = blend_angle(mdl_pitch, s.rate_y, s.step_time, pitch_ang);
    mdl_roll  = blend_angle(mdl_roll, s.rate_x, s.step_time, roll_ang);
    if (res.valid) begin
      azabs = (az < 0) ? -az : az;
      if (r == 0) begin
        hx = (ax > 0) ? mz : -mz;
        hy = my;
      end else begin
        hx = (mx * r + mz * ax) * r;
        hy = -mx * ay * ax + my * azabs * l + mz * ay * r;
      end
      h = floor_shr(vec_atan2(hy, hx) + 256, 9);
      if (h < 0) h += 46080;
      if (h >= 46080) h -= 46080;
      mdl_heading = h[15:0];
    end
    res.pitch = mdl_pitch;
    res.roll = mdl_roll;
    res.heading = mdl_heading;
    return res;
  endfunction

  // apb write, only while the filter is idle
  task automatic write_gain(logic [15:0] gain);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= RegBlendGain; pwdata <= {16'hdead, gain};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    mdl_gain = gain;
    // read back
    @(posedge clk_i);
    psel <= 1'b1; paddr <= RegBlendGain;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[15:0] !== gain) begin
      $error("blend_gain readback: expected %0d actual %0d", gain, prdata[15:0]);
      n_fail++;
    end
    psel <= 1'b0; penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // valid stays up after a word unless the next one idles first
  task automatic send_sample(imu_word_t s);
    while (!quiet_stretch && $urandom_range(99) < 22) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= s;
    expected_att_q.push_back(predict_attitude(s));
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_att_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_field(int mode);
    case (mode)
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'($signed($urandom_range(200)) - 100);
      default: return 16'($urandom);
    endcase
  endfunction

  // plausible sample: mostly gravity-sized readings with random content
  function automatic imu_word_t rand_sample();
    imu_word_t s;
    int md;
    md = $urandom_range(9);
    s = {$urandom, $urandom, $urandom, $urandom, 16'($urandom)};
    if (md < 6) begin
      s.rate_x = 16'($signed($urandom_range(4000)) - 2000);
      s.rate_y = 16'($signed($urandom_range(4000)) - 2000);
      s.acc_x = 16'($signed($urandom_range(8000)) - 4000);
      s.acc_y = 16'($signed($urandom_range(8000)) - 4000);
      s.acc_z = 16'($signed($urandom_range(8000)) - 4000);
      s.step_time = 16'($urandom_range(1000));
    end else if (md < 8) begin
      s.acc_x = rand_field($urandom_range(4));
      s.acc_y = rand_field($urandom_range(4));
      s.acc_z = rand_field($urandom_range(4));
      s.mag_x = rand_field($urandom_range(4));
      s.mag_y = rand_field($urandom_range(4));
      s.mag_z = rand_field($urandom_range(4));
    end else if (md == 8) begin
      s.acc_x = '0; s.acc_y = '0; s.acc_z = '0;
    end else begin
      s.acc_y = '0; s.acc_z = '0;
    end
    return s;
  endfunction

  // result checker with random back-pressure
  always @(posedge clk_i) begin
    attitude_t got, exp_att;
    if (rst_ni) begin
      m_axis_tready <= quiet_stretch ? 1'b1 : ($urandom_range(99) >= 22);
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[47:32], m_axis_tuser};
        n_results++;
        if (!got.valid) n_invalid++;
        if (expected_att_q.size() == 0) begin
          $error("unexpected result word");
          n_fail++;
        end else begin
          exp_att = expected_att_q.pop_front();
          if (got.pitch !== exp_att.pitch) begin
            $error("pitch_angle: expected %0d actual %0d",
                   $signed(exp_att.pitch), $signed(got.pitch));
            n_fail++;
          end
          if (got.roll !== exp_att.roll) begin
            $error("roll_angle: expected %0d actual %0d",
                   $signed(exp_att.roll), $signed(got.roll));
            n_fail++;
          end
          if (got.heading !== exp_att.heading) begin
            $error("heading: expected %0d actual %0d", exp_att.heading, got.heading);
            n_fail++;
          end
          if (got.valid !== exp_att.valid) begin
            $error("heading_valid: expected %0d actual %0d", exp_att.valid, got.valid);
            n_fail++;
          end
        end
      end
    end
  end

  // directed table then random phases
  initial begin
    stim_row_t   rows[$];
    stim_row_t   row;
    attitude_t   pred;
    logic [15:0] gains[5];
    int unsigned cnt;
    gains = '{16'd0, 16'd65535, 16'd32768, 16'd64000, 16'd1000};
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0; m_axis_tready = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    mdl_gain = GainReset; mdl_pitch = '0; mdl_roll = '0; mdl_heading = '0;
    n_fail = 0; n_results = 0; n_invalid = 0; quiet_stretch = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    if (prdata !== {16'd0, GainReset}) begin
      $error("blend_gain after reset: expected %0d actual %0d", GainReset, prdata);
      n_fail++;
    end

    // zero sample after reset: everything stays zero, heading held
    row.smp = '0; row.has_exp = 1; row.exp_att = '0; rows.push_back(row);
    row.has_exp = 0;
    // extremes of every field
    row.smp = {16'hffff, {8{16'h7fff}}}; rows.push_back(row);
    row.smp = {16'h0000, {8{16'h8000}}}; rows.push_back(row);
    row.smp = {16'hffff, {8{16'h8000}}}; rows.push_back(row);
    // zero accel with nonzero rates
    row.smp = '{16'd40000, 16'd100, 16'd200, 16'd300, 0, 0, 0, 16'h7fff, 16'h8000};
    rows.push_back(row);
    // accel along x only, both signs
    row.smp = '{16'd500, 16'd1234, 16'd4321, 16'd77, 0, 0, 16'd4096, 0, 0};
    rows.push_back(row);
    row.smp = '{16'd500, 16'd1234, 16'd4321, 16'd77, 0, 0, 16'hf000, 0, 0};
    rows.push_back(row);
    // zero magnetometer
    row.smp = '{16'd10, 0, 0, 0, 16'd4096, 16'd10, 16'd20, 16'd5, 16'd5};
    rows.push_back(row);
    // negative z, level and inverted
    row.smp = '{16'd65, 16'd100, 16'hff00, 16'd300, 16'hf000, 0, 0, 0, 0};
    rows.push_back(row);
    row.smp = '{16'd65, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 0, 0};
    rows.push_back(row);
    row.smp = '{16'd65, 16'd3, 16'd2, 16'd1, 16'h8000, 16'h8000, 0, 16'h7fff, 16'h7fff};
    rows.push_back(row);
    foreach (rows[k]) begin
      if (rows[k].has_exp) begin
        pred = predict_attitude(rows[k].smp);
        mdl_pitch = '0; mdl_roll = '0; mdl_heading = '0;
        if (pred !== rows[k].exp_att) begin
          $error("directed row %0d: predictor disagrees with table", k);
          n_fail++;
        end
      end
      send_sample(rows[k].smp);
    end
    wait_idle();

    // random phases across several gains, one phase without idling
    cnt = 0;
    foreach (gains[g]) begin
      write_gain(gains[g]);
      quiet_stretch = (g == 2);
      for (int n = 0; n < NumRandom / 5; n++) begin
        send_sample(rand_sample());
        cnt++;
      end
      wait_idle();
    end
    quiet_stretch = 1'b0;
    write_gain(GainReset);
    for (int n = 0; n < 40; n++) send_sample(rand_sample());
    wait_idle();

    $display("covered %0d directed and %0d random samples, %0d results (%0d held heading)",
             rows.size(), cnt + 40, n_results, n_invalid);
    $display("blend gain swept over 0, full scale, midpoint and reset value");
    if (n_fail == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> imu_complementary_attitude.f
hdl/ica_pkg.sv
hdl/ica_front.sv
hdl/ica_cordic.sv
hdl/ica_sqrt.sv
hdl/ica_back.sv
hdl/imu_complementary_attitude.sv
hdl/ica_checker.sv
dv/imu_complementary_attitude_tb.sv
